>>> hdl/lcb_pkg.sv
// Shared types and codes for the least-connections balancer.
// Used by lcb_slot_file, lcb_engine and least_connections_balancer_core.
`timescale 1ns / 1ps

package lcb_pkg;

	// Request opcodes
	localparam logic [1:0] CMD_PICK       = 2'd0;
	localparam logic [1:0] CMD_CONNECT    = 2'd1;
	localparam logic [1:0] CMD_DISCONNECT = 2'd2;
	localparam logic [1:0] CMD_HEALTH     = 2'd3;

	// Response status codes
	localparam logic [2:0] ST_PICKED    = 3'd0;
	localparam logic [2:0] ST_NONE      = 3'd1;
	localparam logic [2:0] ST_MATCHED   = 3'd2;
	localparam logic [2:0] ST_UNMATCHED = 3'd3;
	localparam logic [2:0] ST_HEALTH    = 3'd4;
	localparam logic [2:0] ST_BADSLOT   = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] REG_SLOT_LIMIT = 3'd0;
	localparam logic [2:0] REG_PORT_0     = 3'd1;
	localparam logic [2:0] REG_PORT_1     = 3'd2;
	localparam logic [2:0] REG_PORT_2     = 3'd3;
	localparam logic [2:0] REG_PORT_3     = 3'd4;

	localparam int PORT_REGS = 4;

	// Slot update operations
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_INC    = 2'd1;
	localparam logic [1:0] OP_DEC    = 2'd2;
	localparam logic [1:0] OP_HEALTH = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] event_port;
		logic [1:0]  slot_index;
		logic        reachable;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  chosen_slot;
		logic [15:0] slot_connections;
	} rsp_t;

	// Update control from the sequencer to the slot file
	typedef struct packed {
		logic       en;
		logic [1:0] op;
		logic       up;
	} upd_t;

endpackage

>>> hdl/least_connections_balancer_core.sv
// Least-connections balancer top level: config registers, request intake, response register.
// Depends on lcb_pkg, lcb_engine and lcb_slot_file.
`timescale 1ns / 1ps

// Keeps a 16-bit connection count and an alive flag for each of NUM_SLOTS server slots.
// A pick request returns the alive active slot with the fewest connections (lowest index
// on ties); connect and disconnect requests find the first active slot whose report port
// matches, and bump its count up (saturating) or down (floored at zero); a health request
// writes a slot's alive flag and clears its count on an alive-to-down change. The sequencer
// walks the slots one per cycle through a single shared comparator: a pick and an unmatched
// event visit all n active slots, n being the active slot count (the slot-count register
// capped at NUM_SLOTS), and an event that matches slot k stops there. A health request
// skips the scan, and skips the slot update too when its slot is not in use. One request
// is in flight at a time; a finished response waits in the output register, so the next
// request is taken while the response is still stalled, and a response stall only holds
// the sequencer once that register is occupied.
// Configuration must be written only while no request is in progress.
module least_connections_balancer_core #(
	parameter int NUM_SLOTS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lcb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lcb_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam logic [2:0] MAX_N = 3'(NUM_SLOTS);

	logic [2:0]                                slot_limit_q;
	logic [lcb_pkg::PORT_REGS-1:0][15:0]       port_q;
	logic [2:0]                                active_n;
	logic                                      busy;
	logic                                      res_valid;
	lcb_pkg::rsp_t                             res;
	logic                                      res_take;
	logic                                      rsp_valid_q;
	lcb_pkg::rsp_t                             rsp_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= 3'd2;
			port_q[0]    <= 16'd5001;
			port_q[1]    <= 16'd5001;
			port_q[2]    <= 16'd0;
			port_q[3]    <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcb_pkg::REG_SLOT_LIMIT: slot_limit_q <= cfg_data[2:0];
				lcb_pkg::REG_PORT_0:     port_q[0]    <= cfg_data;
				lcb_pkg::REG_PORT_1:     port_q[1]    <= cfg_data;
				lcb_pkg::REG_PORT_2:     port_q[2]    <= cfg_data;
				lcb_pkg::REG_PORT_3:     port_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Active slot count
	assign active_n = (slot_limit_q > MAX_N) ? MAX_N : slot_limit_q;

	assign req_stall = busy;

	lcb_engine #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid),
		.req      (req),
		.active_n (active_n),
		.ports    (port_q),
		.busy     (busy),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	// Response register
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted request keeps the sequencer busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> busy)
		else $error("accepted request did not start the sequencer");

	// A picked slot always lies inside the active range
	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == lcb_pkg::ST_PICKED |-> {1'b0, rsp.chosen_slot} < active_n)
		else $error("picked slot outside active range");

	// Failure responses carry zero slot and count
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == lcb_pkg::ST_NONE || rsp.status == lcb_pkg::ST_UNMATCHED
		|| rsp.status == lcb_pkg::ST_BADSLOT)
		|-> rsp.chosen_slot == 2'd0 && rsp.slot_connections == 16'd0)
		else $error("failure response with nonzero fields");

endmodule

>>> hdl/lcb_slot_file.sv
// Per-slot connection counters and alive flags with one read and one update port.
// Depends on lcb_pkg.
`timescale 1ns / 1ps

module lcb_slot_file #(
	parameter int NUM_SLOTS = 4,
	parameter int IDX_W = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic [15:0]         rd_count,
	output logic                rd_alive,
	input  lcb_pkg::upd_t       upd,
	output logic [15:0]         nxt_count
);

	logic [15:0] counts_q [NUM_SLOTS];
	logic        alive_q  [NUM_SLOTS];

	// Read port; updates always target the slot being read
	assign rd_count = counts_q[rd_idx];
	assign rd_alive = alive_q[rd_idx];

	// New count for the addressed slot
	always_comb begin
		unique case (upd.op)
			lcb_pkg::OP_INC:    nxt_count = (rd_count != 16'hFFFF) ? rd_count + 16'd1 : rd_count;
			lcb_pkg::OP_DEC:    nxt_count = (rd_count != 16'd0) ? rd_count - 16'd1 : rd_count;
			lcb_pkg::OP_HEALTH: nxt_count = (rd_alive && !upd.up) ? 16'd0 : rd_count;
			default:            nxt_count = rd_count;
		endcase
	end

	// Storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				counts_q[i] <= 16'd0;
				alive_q[i]  <= 1'b1;
			end
		end else if (upd.en) begin
			counts_q[rd_idx] <= nxt_count;
			if (upd.op == lcb_pkg::OP_HEALTH) begin
				alive_q[rd_idx] <= upd.up;
			end
		end
	end

endmodule

>>> hdl/lcb_engine.sv
// Request sequencer: scans one slot per cycle through a shared 16-bit comparator
// as needed and applies at most one slot update. Depends on lcb_pkg and lcb_slot_file.
`timescale 1ns / 1ps

module lcb_engine #(
	parameter int NUM_SLOTS = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  lcb_pkg::req_t                            req,
	input  logic [2:0]                               active_n,
	input  logic [lcb_pkg::PORT_REGS-1:0][15:0]      ports,
	output logic                                     busy,
	output logic                                     res_valid,
	output lcb_pkg::rsp_t                            res,
	input  logic                                     res_take
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	lcb_pkg::req_t    req_q;
	logic [2:0]       n_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] tgt_q;
	logic             found_q;
	logic [IDX_W-1:0] best_q;
	logic [15:0]      best_cnt_q;
	lcb_pkg::rsp_t    res_q;

	logic [IDX_W-1:0] rd_idx;
	logic [15:0]      rd_count;
	logic             rd_alive;
	logic [15:0]      nxt_count;
	lcb_pkg::upd_t    upd;
	logic             is_pick;
	logic             scan_end;
	logic [15:0]      cmp_a;
	logic [15:0]      cmp_b;
	logic             cmp_lt;
	logic             cmp_eq;

	lcb_slot_file #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_count (rd_count),
		.rd_alive (rd_alive),
		.upd      (upd),
		.nxt_count(nxt_count)
	);

	assign is_pick  = (req_q.cmd == lcb_pkg::CMD_PICK);
	assign scan_end = (3'(idx_q) == n_q);
	assign rd_idx   = (state_q == S_UPD) ? tgt_q : IDX_W'(idx_q);

	// Shared comparator: count against best for picks, port against event port
	assign cmp_a  = is_pick ? rd_count : ports[2'(idx_q)];
	assign cmp_b  = is_pick ? best_cnt_q : req_q.event_port;
	assign cmp_lt = (cmp_a < cmp_b);
	assign cmp_eq = (cmp_a == cmp_b);

	// Slot update request
	always_comb begin
		upd.en = (state_q == S_UPD);
		upd.up = req_q.reachable;
		unique case (req_q.cmd)
			lcb_pkg::CMD_CONNECT:    upd.op = lcb_pkg::OP_INC;
			lcb_pkg::CMD_DISCONNECT: upd.op = lcb_pkg::OP_DEC;
			lcb_pkg::CMD_HEALTH:     upd.op = lcb_pkg::OP_HEALTH;
			default:                 upd.op = lcb_pkg::OP_NONE;
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.cmd == lcb_pkg::CMD_HEALTH) begin
							state_q <= ({1'b0, req.slot_index} < active_n) ? S_UPD : S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end else if (!is_pick && cmp_eq) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_DONE;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q   <= req;
					n_q     <= active_n;
					idx_q   <= '0;
					found_q <= 1'b0;
					best_q  <= '0;
					tgt_q   <= IDX_W'(req.slot_index);
					res_q   <= '{status: lcb_pkg::ST_BADSLOT, chosen_slot: 2'd0,
						slot_connections: 16'd0};
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					if (is_pick && found_q) begin
						res_q <= '{status: lcb_pkg::ST_PICKED, chosen_slot: 2'(best_q),
							slot_connections: best_cnt_q};
					end else begin
						res_q <= '{status: is_pick ? lcb_pkg::ST_NONE : lcb_pkg::ST_UNMATCHED,
							chosen_slot: 2'd0, slot_connections: 16'd0};
					end
				end else begin
					idx_q <= idx_q + CNT_W'(1);
					if (is_pick) begin
						if (rd_alive && (!found_q || cmp_lt)) begin
							found_q    <= 1'b1;
							best_q     <= IDX_W'(idx_q);
							best_cnt_q <= rd_count;
						end
					end else if (cmp_eq) begin
						tgt_q <= IDX_W'(idx_q);
					end
				end
			end
			S_UPD: begin
				res_q <= '{status: (req_q.cmd == lcb_pkg::CMD_HEALTH) ? lcb_pkg::ST_HEALTH
					: lcb_pkg::ST_MATCHED, chosen_slot: 2'(tgt_q), slot_connections: nxt_count};
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule
